FILE: sv/mom_pkg.sv
`default_nettype none
package mom_pkg;

  localparam int MAIN_DEPTH = 64;
  localparam int SIDE_DEPTH = 64;

  localparam int MAIN_AW = $clog2(MAIN_DEPTH);
  localparam int SIDE_AW = $clog2(SIDE_DEPTH);
  localparam int MAIN_CW = $clog2(MAIN_DEPTH + 1);
  localparam int SIDE_CW = $clog2(SIDE_DEPTH + 1);
  localparam int MAIN_SW = MAIN_AW + 1;
  localparam int SIDE_SW = SIDE_AW + 1;

  localparam int IN_DATA_W  = 8;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    MODE_MAIN  = 2'd0,
    MODE_SIDE  = 2'd1,
    MODE_READY = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  // MIDI byte classes
  localparam logic [7:0] STATUS_MIN  = 8'h80;
  localparam logic [7:0] SYSTEM_MIN  = 8'hF0;
  localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
  localparam logic [3:0] NIB_POLY_AT  = 4'hA;
  localparam logic [3:0] NIB_CTRL     = 4'hB;
  localparam logic [3:0] NIB_PROG     = 4'hC;
  localparam logic [3:0] NIB_CHAN_AT  = 4'hD;
  localparam logic [3:0] NIB_BEND     = 4'hE;
  localparam logic [7:0] SYSEX_START = 8'hF0;
  localparam logic [7:0] TIME_CODE   = 8'hF1;
  localparam logic [7:0] SONG_POS    = 8'hF2;
  localparam logic [7:0] SONG_SEL    = 8'hF3;
  localparam logic [7:0] SYSEX_END   = 8'hF7;

  localparam logic signed [2:0] REM_SYSEX = -3'sd1;
  localparam logic signed [2:0] REM_NONE  = 3'sd0;
  localparam logic signed [2:0] REM_ONE   = 3'sd1;
  localparam logic signed [2:0] REM_TWO   = 3'sd2;

  typedef struct packed {
    logic       push_accepted;
    logic       sent_valid;
    logic [7:0] sent_byte;
    logic       sent_from_side;
    logic       transmitter_idle;
  } res_t;

  typedef struct packed {
    logic       upd;
    logic [7:0] byte_val;
  } trk_t;

endpackage
`default_nettype wire

FILE: sv/mom_ram.sv
`default_nettype none
module mom_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: sv/mom_track.sv
`default_nettype none
module mom_track (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mom_pkg::trk_t     trk,
  output logic                   rem_zero,
  output logic signed [2:0]      rem_nxt
);
  import mom_pkg::*;

  logic signed [2:0] rem_r;
  logic signed [2:0] dec;
  logic [7:0]        c;

  assign c = trk.byte_val;

  always_comb begin
    dec = rem_r;
    if (rem_r > REM_NONE && c < STATUS_MIN) begin
      dec = rem_r - 3'sd1;
    end
    rem_nxt = rem_r;
    if (trk.upd) begin
      rem_nxt = dec;
      if (c < SYSTEM_MIN) begin
        case (c[7:4])
          NIB_PROG, NIB_CHAN_AT: rem_nxt = REM_ONE;
          NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_AT, NIB_CTRL, NIB_BEND: rem_nxt = REM_TWO;
          default: rem_nxt = dec;
        endcase
      end else begin
        case (c)
          SYSEX_START: rem_nxt = REM_SYSEX;
          TIME_CODE:   rem_nxt = REM_ONE;
          SONG_POS:    rem_nxt = REM_TWO;
          SONG_SEL:    rem_nxt = REM_ONE;
          SYSEX_END:   rem_nxt = REM_NONE;
          default:     rem_nxt = dec;
        endcase
      end
    end
  end

  assign rem_zero = (rem_r == REM_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= REM_NONE;
    end else begin
      rem_r <= rem_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/mom_ctl.sv
`default_nettype none
module mom_ctl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   fire,
  input  wire mom_pkg::mode_t         mode,
  input  wire logic [7:0]             data_byte,
  input  wire logic                   rem_zero,
  output logic                        main_we,
  output logic [mom_pkg::MAIN_AW-1:0] main_waddr,
  output logic [mom_pkg::MAIN_AW-1:0] main_raddr,
  input  wire logic [7:0]             main_rdata,
  output logic                        side_we,
  output logic [mom_pkg::SIDE_AW-1:0] side_waddr,
  output logic [mom_pkg::SIDE_AW-1:0] side_raddr,
  input  wire logic [7:0]             side_rdata,
  output mom_pkg::res_t               res,
  output mom_pkg::trk_t               trk
);
  import mom_pkg::*;

  logic [MAIN_AW-1:0] main_head_r, main_head_nxt;
  logic [MAIN_CW-1:0] main_count_r, main_count_nxt;
  logic [SIDE_AW-1:0] side_head_r, side_head_nxt;
  logic [SIDE_CW-1:0] side_count_r, side_count_nxt;
  logic               main_byp_r, side_byp_r;
  logic [7:0]         byp_data_r;
  logic [7:0]         main_front, side_front;
  logic [MAIN_SW-1:0] main_sum;
  logic [SIDE_SW-1:0] side_sum;
  logic               is_ready, side_sel, pop_main, pop_side;

  // Head bytes: registered RAM read, or the byte just pushed into an empty queue
  assign main_front = main_byp_r ? byp_data_r : main_rdata;
  assign side_front = side_byp_r ? byp_data_r : side_rdata;

  assign main_we  = fire && (mode == MODE_MAIN) && (main_count_r < MAIN_CW'(MAIN_DEPTH));
  assign side_we  = fire && (mode == MODE_SIDE) && (side_count_r < SIDE_CW'(SIDE_DEPTH));
  assign is_ready = fire && (mode == MODE_READY);
  assign side_sel = (side_count_r != '0) && rem_zero;
  assign pop_side = is_ready && side_sel;
  assign pop_main = is_ready && !side_sel && (main_count_r != '0);

  assign main_sum = MAIN_SW'(main_head_r) + MAIN_SW'(main_count_r);
  assign side_sum = SIDE_SW'(side_head_r) + SIDE_SW'(side_count_r);
  assign main_waddr = (main_sum >= MAIN_SW'(MAIN_DEPTH)) ?
                      MAIN_AW'(main_sum - MAIN_SW'(MAIN_DEPTH)) : MAIN_AW'(main_sum);
  assign side_waddr = (side_sum >= SIDE_SW'(SIDE_DEPTH)) ?
                      SIDE_AW'(side_sum - SIDE_SW'(SIDE_DEPTH)) : SIDE_AW'(side_sum);

  always_comb begin
    main_head_nxt  = main_head_r;
    main_count_nxt = main_count_r;
    side_head_nxt  = side_head_r;
    side_count_nxt = side_count_r;
    if (main_we) begin
      main_count_nxt = main_count_r + 1'b1;
    end
    if (side_we) begin
      side_count_nxt = side_count_r + 1'b1;
    end
    if (pop_main) begin
      main_count_nxt = main_count_r - 1'b1;
      main_head_nxt  = (main_head_r == MAIN_AW'(MAIN_DEPTH - 1)) ? '0 : main_head_r + 1'b1;
    end
    if (pop_side) begin
      side_count_nxt = side_count_r - 1'b1;
      side_head_nxt  = (side_head_r == SIDE_AW'(SIDE_DEPTH - 1)) ? '0 : side_head_r + 1'b1;
    end
  end

  // Prefetch the head that the next transaction will see
  assign main_raddr = main_head_nxt;
  assign side_raddr = side_head_nxt;

  always_comb begin
    res.push_accepted    = main_we || side_we;
    res.sent_valid       = pop_main || pop_side;
    res.sent_byte        = pop_side ? side_front : (pop_main ? main_front : 8'h00);
    res.sent_from_side   = pop_side;
    res.transmitter_idle = (main_count_nxt == '0) && (side_count_nxt == '0);
    trk.upd              = pop_main;
    trk.byte_val         = main_front;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_head_r  <= '0;
      main_count_r <= '0;
      side_head_r  <= '0;
      side_count_r <= '0;
      main_byp_r   <= 1'b0;
      side_byp_r   <= 1'b0;
    end else begin
      main_head_r  <= main_head_nxt;
      main_count_r <= main_count_nxt;
      side_head_r  <= side_head_nxt;
      side_count_r <= side_count_nxt;
      main_byp_r   <= main_we && (main_count_r == '0);
      side_byp_r   <= side_we && (side_count_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= data_byte;
  end

endmodule
`default_nettype wire

FILE: sv/midi_output_merger_top.sv
`default_nettype none
// An input transaction passes the input register, then queue update and
// arbitration into the result register.
// Throughput: one transaction per cycle while out_tready drains results, set
// by the queue pointer update and the prefetched head read of each queue RAM.
// Reset (rst_n low, synchronous) empties both queues and clears message state;
// queue RAM contents are not cleared and no clearing pass runs.
module midi_output_merger_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic [1:0]  in_tuser,   // [1:0] mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // [0] push_accepted, [1] sent_valid,
                                       // [9:2] sent_byte, [10] sent_from_side,
                                       // [11] transmitter_idle,
                                       // [14:12] bytes_pending, [15] zero
);
  import mom_pkg::*;

  logic              s1_valid_r;
  mode_t             s1_mode_r;
  logic [7:0]        s1_byte_r;
  logic              fire;
  logic              out_valid_r;
  logic [15:0]       out_data_r;

  logic               main_we, side_we, rem_zero;
  logic [MAIN_AW-1:0] main_waddr, main_raddr;
  logic [SIDE_AW-1:0] side_waddr, side_raddr;
  logic [7:0]         main_rdata, side_rdata;
  res_t               res;
  trk_t               trk;
  logic signed [2:0]  rem_nxt;

  // Execute when the result register is free or being drained
  assign fire      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_mode_r <= mode_t'(in_tuser);
      s1_byte_r <= in_tdata;
    end
    if (fire) begin
      out_data_r <= {1'b0, rem_nxt, res.transmitter_idle, res.sent_from_side,
                     res.sent_byte, res.sent_valid, res.push_accepted};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  mom_ctl u_ctl (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .mode       (s1_mode_r),
    .data_byte  (s1_byte_r),
    .rem_zero   (rem_zero),
    .main_we    (main_we),
    .main_waddr (main_waddr),
    .main_raddr (main_raddr),
    .main_rdata (main_rdata),
    .side_we    (side_we),
    .side_waddr (side_waddr),
    .side_raddr (side_raddr),
    .side_rdata (side_rdata),
    .res        (res),
    .trk        (trk)
  );

  mom_ram #(.DEPTH(MAIN_DEPTH), .WIDTH(8), .AW(MAIN_AW)) u_main_ram (
    .clk   (clk),
    .we    (main_we),
    .waddr (main_waddr),
    .wdata (s1_byte_r),
    .raddr (main_raddr),
    .rdata (main_rdata)
  );

  mom_ram #(.DEPTH(SIDE_DEPTH), .WIDTH(8), .AW(SIDE_AW)) u_side_ram (
    .clk   (clk),
    .we    (side_we),
    .waddr (side_waddr),
    .wdata (s1_byte_r),
    .raddr (side_raddr),
    .rdata (side_rdata)
  );

  mom_track u_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .trk      (trk),
    .rem_zero (rem_zero),
    .rem_nxt  (rem_nxt)
  );

endmodule
`default_nettype wire

FILE: verif/midi_output_merger_checker.sv
`default_nettype none
module midi_output_merger_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic [1:0]  in_tuser,   // [1:0] mode
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [15:0] out_tdata,  // [0] push_accepted, [1] sent_valid,
                                       // [9:2] sent_byte, [10] sent_from_side,
                                       // [11] transmitter_idle,
                                       // [14:12] bytes_pending, [15] zero
  output int               fail_count,
  output int               expect_left
);
  import mom_pkg::*;

  localparam int REPORT_MAX = 10;

  logic [7:0]         main_q [MAIN_DEPTH];
  logic [MAIN_AW-1:0] main_rd;
  logic [MAIN_CW-1:0] main_fill;
  logic [7:0]         side_q [SIDE_DEPTH];
  logic [SIDE_AW-1:0] side_rd;
  logic [SIDE_CW-1:0] side_fill;
  logic signed [2:0]  msg_left;

  logic [15:0] expected_words [$];
  logic [15:0] want;
  int          reported;

  initial begin
    fail_count  = 0;
    expect_left = 0;
    reported    = 0;
  end

  // Data bytes left in the main-channel message after byte c goes out.
  function automatic logic signed [2:0] next_msg_left(logic signed [2:0] cur,
                                                      logic [7:0] c);
    logic signed [2:0] r;
    r = cur;
    if (r > 0 && c < STATUS_MIN) r = r - 3'sd1;
    if (c < SYSTEM_MIN) begin
      case (c[7:4])
        NIB_PROG, NIB_CHAN_AT: r = REM_ONE;
        NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_AT, NIB_CTRL, NIB_BEND: r = REM_TWO;
        default: ;
      endcase
    end else begin
      case (c)
        SYSEX_START:         r = REM_SYSEX;
        TIME_CODE, SONG_SEL: r = REM_ONE;
        SONG_POS:            r = REM_TWO;
        SYSEX_END:           r = REM_NONE;
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic predict_merge(mode_t m, logic [7:0] b);
    logic       acc;
    logic       vld;
    logic       from_side;
    logic [7:0] sent;
    acc       = 1'b0;
    vld       = 1'b0;
    from_side = 1'b0;
    sent      = '0;
    case (m)
      MODE_MAIN: begin
        if (main_fill < MAIN_DEPTH) begin
          main_q[MAIN_AW'(main_rd + main_fill)] = b;
          main_fill = main_fill + 1'b1;
          acc = 1'b1;
        end
      end
      MODE_SIDE: begin
        if (side_fill < SIDE_DEPTH) begin
          side_q[SIDE_AW'(side_rd + side_fill)] = b;
          side_fill = side_fill + 1'b1;
          acc = 1'b1;
        end
      end
      MODE_READY: begin
        // side traffic only slips in between main-channel messages
        if (side_fill != 0 && msg_left == REM_NONE) begin
          sent      = side_q[side_rd];
          side_rd   = side_rd + 1'b1;
          side_fill = side_fill - 1'b1;
          vld       = 1'b1;
          from_side = 1'b1;
        end else if (main_fill != 0) begin
          sent      = main_q[main_rd];
          main_rd   = main_rd + 1'b1;
          main_fill = main_fill - 1'b1;
          vld       = 1'b1;
          msg_left  = next_msg_left(msg_left, sent);
        end
      end
      default: ;
    endcase
    expected_words.push_back({1'b0, msg_left, (main_fill == 0 && side_fill == 0),
                              from_side, sent, vld, acc});
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      main_rd   = '0;
      main_fill = '0;
      side_rd   = '0;
      side_fill = '0;
      msg_left  = REM_NONE;
      expected_words.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          fail_count++;
          if (reported < REPORT_MAX) begin
            reported++;
            $display("unexpected result transaction %h", out_tdata);
          end
        end else begin
          want = expected_words.pop_front();
          if (want !== out_tdata) begin
            fail_count++;
            if (reported < REPORT_MAX) begin
              reported++;
              $display("mismatch: expected acc=%0d vld=%0d byte=%02h side=%0d ",
                       want[0], want[1], want[9:2], want[10],
                       "idle=%0d pend=%0d top=%0d, ",
                       want[11], $signed(want[14:12]), want[15],
                       "got acc=%0d vld=%0d byte=%02h side=%0d ",
                       out_tdata[0], out_tdata[1], out_tdata[9:2], out_tdata[10],
                       "idle=%0d pend=%0d top=%0d",
                       out_tdata[11], $signed(out_tdata[14:12]), out_tdata[15]);
            end
          end
        end
      end
      if (in_tvalid && in_tready) predict_merge(mode_t'(in_tuser), in_tdata);
    end
    expect_left = expected_words.size();
  end

endmodule
`default_nettype wire

FILE: verif/midi_output_merger_top_tb.sv
`default_nettype none
module midi_output_merger_top_tb;
  import mom_pkg::*;

  localparam int ITEM_TARGET  = 1700;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 10;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic [1:0]  in_tuser   = MODE_NOP;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  int fail_count;
  int expect_left;
  int items_sent   = 0;
  int quiet_cycles = 0;
  int rx_wait      = 0;
  bit tx_steady    = 1'b0;
  bit rx_steady    = 1'b0;
  bit out_fire     = 1'b0;

  midi_output_merger_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  midi_output_merger_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .expect_left (expect_left)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side: after each transaction, hold off out_tready for a random wait unless rx_steady is set.
  always @(posedge clk) out_fire <= out_tvalid && out_tready;

  always @(negedge clk) begin
    if (out_fire) begin
      if ($urandom_range(0, 99) == 0) rx_steady = !rx_steady;
      rx_wait = rx_steady ? 0 : $urandom_range(0, 6);
    end
    if (rx_wait > 0) begin
      out_tready <= 1'b0;
      rx_wait--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send(mode_t m, logic [7:0] b);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    if (m != MODE_NOP) items_sent++;
  endtask

  // Push one main byte and mix in side traffic and transmitter-ready events.
  task automatic main_byte(logic [7:0] b);
    int n;
    send(MODE_MAIN, b);
    n = $urandom_range(0, 9);
    if (n < 6) begin
      send(MODE_READY, 8'($urandom));
    end else if (n == 6) begin
      send(MODE_SIDE, 8'($urandom));
      send(MODE_READY, 8'($urandom));
    end else if (n < 9) begin
      send(MODE_READY, 8'($urandom));
      send(MODE_READY, 8'($urandom));
    end else begin
      send(MODE_SIDE, 8'($urandom));
    end
  endtask

  task automatic midi_message();
    int kind;
    int k;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1: begin
        main_byte(8'(8'h80 + $urandom_range(0, 8'h3F)));
        repeat (2) main_byte(8'($urandom_range(0, 8'h7F)));
      end
      2: begin
        main_byte(8'(8'hE0 + $urandom_range(0, 8'h0F)));
        repeat (2) main_byte(8'($urandom_range(0, 8'h7F)));
      end
      3: begin
        main_byte(8'(8'hC0 + $urandom_range(0, 8'h1F)));
        main_byte(8'($urandom_range(0, 8'h7F)));
      end
      4: begin
        main_byte($urandom_range(0, 1) ? TIME_CODE : SONG_SEL);
        main_byte(8'($urandom_range(0, 8'h7F)));
      end
      5: begin
        main_byte(SONG_POS);
        repeat (2) main_byte(8'($urandom_range(0, 8'h7F)));
      end
      6: begin
        main_byte(SYSEX_START);
        repeat ($urandom_range(0, 6)) main_byte(8'($urandom_range(0, 8'h7F)));
        main_byte(SYSEX_END);
      end
      7: begin
        // real-time, undefined and tune-request system bytes leave the count alone
        k = $urandom_range(0, 10);
        main_byte(k < 3 ? 8'(8'hF4 + k) : 8'(8'hF8 + k - 3));
      end
      8: begin
        // running status: data bytes with no new status
        repeat ($urandom_range(1, 2)) main_byte(8'($urandom_range(0, 8'h7F)));
      end
      default: main_byte(8'($urandom));
    endcase
  endtask

  // Fill one queue to or past its depth, then send ready events to drain it.
  task automatic fill_and_drain();
    mode_t m;
    m = $urandom_range(0, 1) ? MODE_SIDE : MODE_MAIN;
    repeat ($urandom_range(64, 70)) send(m, 8'($urandom));
    repeat ($urandom_range(60, 75)) send(MODE_READY, 8'($urandom));
  endtask

  initial begin
    int sel;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send(MODE_READY, 8'h00);   // nothing to send
    send(MODE_NOP,   8'hFF);
    send(MODE_MAIN,  8'h90);
    send(MODE_MAIN,  8'h3C);
    send(MODE_MAIN,  8'h7F);
    send(MODE_SIDE,  8'hF8);
    send(MODE_READY, 8'hFF);   // side wins while no main message is in progress
    send(MODE_READY, 8'h00);
    send(MODE_SIDE,  8'hFE);
    send(MODE_READY, 8'h00);   // side held back mid-message
    send(MODE_READY, 8'h00);
    send(MODE_READY, 8'h00);
    send(MODE_MAIN,  SYSEX_START);
    send(MODE_MAIN,  8'h00);
    send(MODE_MAIN,  SYSEX_END);
    send(MODE_SIDE,  8'h00);
    send(MODE_READY, 8'h00);
    send(MODE_READY, 8'h00);
    send(MODE_READY, 8'h00);
    send(MODE_READY, 8'h00);
    send(MODE_MAIN,  SONG_POS);
    send(MODE_MAIN,  8'hFF);
    send(MODE_READY, 8'h00);
    send(MODE_READY, 8'h00);   // real-time byte inside a message
    send(MODE_READY, 8'h00);   // main empty, side empty

    while (items_sent < ITEM_TARGET) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        fill_and_drain();
      end else if (sel == 1) begin
        repeat (20) send(mode_t'($urandom_range(0, 3)), 8'($urandom));
      end else begin
        repeat ($urandom_range(3, 10)) midi_message();
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expect_left != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && expect_left == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
